// ===== rtl/zrl_pkg.sv =====
`timescale 1ns / 1ps
// zrl_pkg: shared types, codes and defaults of the zone reservation lock table
// no dependencies

package zrl_pkg;

   localparam int ZONES_DEF          = 64;
   localparam int WAITERS_DEF        = 16;
   localparam int CHANGE_WAITERS_DEF = 16;
   localparam logic [6:0] ZONES_IN_USE_RST = 7'd64;

   typedef enum logic [2:0] {
      ACT_RESERVE       = 3'd0,
      ACT_UNRESERVE     = 3'd1,
      ACT_UNRESERVE_ALL = 3'd2,
      ACT_IS_RESERVED   = 3'd3,
      ACT_WAIT          = 3'd4,
      ACT_WAIT_CHANGE   = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_LOOK,
      ST_SWEEP_CHK,
      ST_SCAN,
      ST_SWEEP_DONE,
      ST_CHG_RD,
      ST_CHG_EMIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [7:0] tid;
      logic [7:0] train;
      logic [5:0] zone;
   } waiter_type;

   typedef struct packed {
      logic       append;
      logic       remove;
      waiter_type entry;
   } wcmd_type;

   typedef struct packed {
      logic [7:0] reply_to;
      logic [2:0] reply_kind;
      logic       granted;
      logic       overflow;
   } reply_type;

endpackage

// ===== rtl/zrl_ifs.sv =====
`timescale 1ns / 1ps
// zrl_ifs: request, reply and register write channels
// no dependencies

interface zrl_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] requester;
   logic [7:0] train;
   logic [5:0] zone;
   modport source (output valid, action, requester, train, zone, input ready);
   modport sink (input valid, action, requester, train, zone, output ready);
endinterface

interface zrl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reply_to;
   logic [2:0] reply_kind;
   logic       granted;
   logic       overflow;
   logic       last;
   modport source (output valid, reply_to, reply_kind, granted, overflow, last, input ready);
   modport sink (input valid, reply_to, reply_kind, granted, overflow, last, output ready);
endinterface

interface zrl_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] zones_in_use;
   modport source (output valid, zones_in_use, input ready);
   modport sink (input valid, zones_in_use, output ready);
endinterface

// ===== rtl/zrl_ram.sv =====
`timescale 1ns / 1ps
// zrl_ram: generic single write port ram with registered read
// no dependencies

module zrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/zrl_waiters.sv =====
`timescale 1ns / 1ps
// zrl_waiters: packed wait queue in arrival order, append at the tail, remove anywhere
// depends on zrl_pkg

module zrl_waiters #(
   parameter int WAITERS = zrl_pkg::WAITERS_DEF,
   localparam int WIW = (WAITERS > 1) ? $clog2(WAITERS) : 1,
   localparam int WCW = $clog2(WAITERS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  zrl_pkg::wcmd_type  cmd,
   input  logic [WIW-1:0]     idx,
   output zrl_pkg::waiter_type entry,
   output logic [WCW-1:0]     count
);
   import zrl_pkg::*;

   waiter_type     store_ff [WAITERS];
   waiter_type     store_in [WAITERS];
   logic [WCW-1:0] cnt_ff, cnt_in;

   for (genvar j = 0; j < WAITERS; j++) begin : g_slot
      always_comb begin
         store_in[j] = store_ff[j];
         if (cmd.append && cnt_ff == WCW'(j)) begin
            store_in[j] = cmd.entry;
         end else if (cmd.remove && WIW'(j) >= idx) begin
            if (j < WAITERS - 1) begin
               store_in[j] = store_ff[(j < WAITERS - 1) ? j + 1 : j];
            end
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.append) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.remove) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      for (int k = 0; k < WAITERS; k++) begin
         store_ff[k] <= store_in[k];
      end
   end

   assign entry = store_ff[idx];
   assign count = cnt_ff;

endmodule

// ===== rtl/zone_reservation_lock_table.sv =====
`timescale 1ns / 1ps
// one request at a time, ready only in idle
// unreserve scans the wait queue one entry a cycle, stalling on a match while the
// reply output is full; unreserve-all reads the owner of each swept zone and adds a
// queue scan per freed zone; each released wait-change reply is read through the
// change ram read port; synchronous active high reset frees all zones, empties both
// queues and sets zones_in_use to 64
module zone_reservation_lock_table #(
   parameter int ZONES          = zrl_pkg::ZONES_DEF,
   parameter int WAITERS        = zrl_pkg::WAITERS_DEF,
   parameter int CHANGE_WAITERS = zrl_pkg::CHANGE_WAITERS_DEF
) (
   input logic       clock,
   input logic       reset,
   zrl_req_if.sink   req,
   zrl_rsp_if.source rsp,
   zrl_csr_if.sink   csr
);
   import zrl_pkg::*;

   localparam int ZW  = $clog2(ZONES);
   localparam int ZCW = ($clog2(ZONES + 1) > 7) ? $clog2(ZONES + 1) : 7;
   localparam int WIW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
   localparam int WCW = $clog2(WAITERS + 1);
   localparam int CIW = (CHANGE_WAITERS > 1) ? $clog2(CHANGE_WAITERS) : 1;
   localparam int CCW = $clog2(CHANGE_WAITERS + 1);

   state_type      state_ff, state_in;
   action_type     act_ff, act_in;
   logic [7:0]     tid_ff, tid_in, train_ff, train_in, cur_owner_ff, cur_owner_in;
   logic [ZCW-1:0] zone_ff, zone_in;
   logic [WIW-1:0] wi_ff, wi_in;
   logic [CIW-1:0] ci_ff, ci_in;
   logic [CCW-1:0] ccnt_ff, ccnt_in;
   logic [6:0]     ziu_ff, ziu_in;
   reply_type      hold_ff, hold_in, out_ff, out_in;
   logic           hold_vld_ff, hold_vld_in, out_vld_ff, out_vld_in, out_last_ff, out_last_in;
   logic [ZONES-1:0] owner_vld_ff, owner_vld_in;
   logic           vldq_ff, vldq_in;

   logic           own_we;
   logic [7:0]     own_wdata, owner_rd, owner_eff, chg_rd;
   logic           chg_we;
   logic [ZW-1:0]  zaddr;
   logic           in_range, held, out_free, emit_ok, emit, flush;
   logic [ZCW-1:0] lim, zone_next;
   reply_type      emit_data;
   wcmd_type       wcmd;
   waiter_type     w_entry;
   logic [WCW-1:0] wcnt;
   logic           w_match;

   zrl_ram #(.WIDTH(8), .DEPTH(ZONES)) u_owner_ram (
      .clock(clock), .we(own_we), .waddr(zaddr), .wdata(own_wdata),
      .raddr(zaddr), .rdata(owner_rd)
   );

   zrl_ram #(.WIDTH(8), .DEPTH(CHANGE_WAITERS)) u_change_ram (
      .clock(clock), .we(chg_we), .waddr(ccnt_ff[CIW-1:0]), .wdata(tid_ff),
      .raddr(ci_ff), .rdata(chg_rd)
   );

   zrl_waiters #(.WAITERS(WAITERS)) u_waiters (
      .clock(clock), .reset(reset), .cmd(wcmd), .idx(wi_ff),
      .entry(w_entry), .count(wcnt)
   );

   assign zaddr     = zone_ff[ZW-1:0];
   assign in_range  = zone_ff < ZCW'(ZONES);
   assign owner_eff = (in_range && vldq_ff) ? owner_rd : 8'd0;
   assign held      = (owner_eff != 8'd0) && (owner_eff != train_ff);
   assign lim       = (ZCW'(ziu_ff) > ZCW'(ZONES)) ? ZCW'(ZONES) : ZCW'(ziu_ff);
   assign zone_next = zone_ff + 1'b1;
   assign out_free  = !out_vld_ff || rsp.ready;
   assign emit_ok   = !hold_vld_ff || out_free;
   // first queued waiter for this zone that the current owner does not block
   assign w_match   = (ZCW'(w_entry.zone) == zone_ff) &&
                      !((cur_owner_ff != 8'd0) && (cur_owner_ff != w_entry.train));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ccnt_ff      <= '0;
         ziu_ff       <= ZONES_IN_USE_RST;
         hold_vld_ff  <= 1'b0;
         out_vld_ff   <= 1'b0;
         owner_vld_ff <= '0;
      end else begin
         state_ff     <= state_in;
         ccnt_ff      <= ccnt_in;
         ziu_ff       <= ziu_in;
         hold_vld_ff  <= hold_vld_in;
         out_vld_ff   <= out_vld_in;
         owner_vld_ff <= owner_vld_in;
      end
      act_ff       <= act_in;
      tid_ff       <= tid_in;
      train_ff     <= train_in;
      cur_owner_ff <= cur_owner_in;
      zone_ff      <= zone_in;
      wi_ff        <= wi_in;
      ci_ff        <= ci_in;
      hold_ff      <= hold_in;
      out_ff       <= out_in;
      out_last_ff  <= out_last_in;
      vldq_ff      <= vldq_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      tid_in       = tid_ff;
      train_in     = train_ff;
      cur_owner_in = cur_owner_ff;
      zone_in      = zone_ff;
      wi_in        = wi_ff;
      ci_in        = ci_ff;
      ccnt_in      = ccnt_ff;
      own_we       = 1'b0;
      own_wdata    = 8'd0;
      chg_we       = 1'b0;
      wcmd         = '0;
      emit         = 1'b0;
      emit_data    = '0;
      flush        = 1'b0;
      req.ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               act_in   = action_type'(req.action);
               tid_in   = req.requester;
               train_in = req.train;
               zone_in  = (action_type'(req.action) == ACT_UNRESERVE_ALL) ? '0 :
                          ZCW'(req.zone);
               if (action_type'(req.action) == ACT_UNRESERVE_ALL && lim == '0) begin
                  state_in = ST_SWEEP_DONE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = (act_ff == ACT_UNRESERVE_ALL) ? ST_SWEEP_CHK : ST_LOOK;
         end
         ST_LOOK: begin
            if (emit_ok) begin
               emit_data.reply_to   = tid_ff;
               emit_data.reply_kind = act_ff;
               state_in = ST_FINISH;
               case (act_ff)
                  ACT_RESERVE: begin
                     emit = 1'b1;
                     emit_data.granted = in_range &&
                                         (owner_eff == train_ff || owner_eff == 8'd0);
                     if (in_range && owner_eff == 8'd0) begin
                        own_we    = 1'b1;
                        own_wdata = train_ff;
                     end
                     ci_in    = '0;
                     state_in = (ccnt_ff != '0) ? ST_CHG_RD : ST_FINISH;
                  end
                  ACT_UNRESERVE: begin
                     emit = 1'b1;
                     emit_data.granted = !held;
                     cur_owner_in = owner_eff;
                     if (owner_eff != 8'd0 && !held) begin
                        own_we       = 1'b1;
                        cur_owner_in = 8'd0;
                     end
                     wi_in    = '0;
                     state_in = ST_SCAN;
                  end
                  ACT_IS_RESERVED: begin
                     emit = 1'b1;
                     emit_data.granted = held;
                  end
                  ACT_WAIT: begin
                     if (!held) begin
                        emit = 1'b1;
                     end else if (wcnt == WCW'(WAITERS)) begin
                        emit = 1'b1;
                        emit_data.overflow = 1'b1;
                     end else begin
                        wcmd.append      = 1'b1;
                        wcmd.entry.tid   = tid_ff;
                        wcmd.entry.train = train_ff;
                        wcmd.entry.zone  = zone_ff[5:0];
                     end
                  end
                  ACT_WAIT_CHANGE: begin
                     if (ccnt_ff == CCW'(CHANGE_WAITERS)) begin
                        emit = 1'b1;
                        emit_data.overflow = 1'b1;
                     end else begin
                        chg_we  = 1'b1;
                        ccnt_in = ccnt_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP_CHK: begin
            if (owner_eff == train_ff) begin
               own_we       = 1'b1;
               cur_owner_in = 8'd0;
               wi_in        = '0;
               state_in     = ST_SCAN;
            end else if (zone_next >= lim) begin
               state_in = ST_SWEEP_DONE;
            end else begin
               zone_in  = zone_next;
               state_in = ST_RD;
            end
         end
         ST_SCAN: begin
            if (WCW'(wi_ff) < wcnt && w_match && !emit_ok) begin
               state_in = ST_SCAN;
            end else begin
               if (WCW'(wi_ff) < wcnt && !w_match && wi_ff != WIW'(WAITERS - 1)) begin
                  wi_in = wi_ff + 1'b1;
               end else begin
                  if (WCW'(wi_ff) < wcnt && w_match) begin
                     emit                 = 1'b1;
                     emit_data.reply_to   = w_entry.tid;
                     emit_data.reply_kind = ACT_WAIT;
                     wcmd.remove          = 1'b1;
                  end
                  // scan over: carry on with the sweep or the change waiters
                  if (act_ff == ACT_UNRESERVE_ALL) begin
                     if (zone_next >= lim) begin
                        state_in = ST_SWEEP_DONE;
                     end else begin
                        zone_in  = zone_next;
                        state_in = ST_RD;
                     end
                  end else begin
                     ci_in    = '0;
                     state_in = (ccnt_ff != '0) ? ST_CHG_RD : ST_FINISH;
                  end
               end
            end
         end
         ST_SWEEP_DONE: begin
            if (emit_ok) begin
               emit                 = 1'b1;
               emit_data.reply_to   = tid_ff;
               emit_data.reply_kind = ACT_UNRESERVE_ALL;
               ci_in                = '0;
               state_in             = (ccnt_ff != '0) ? ST_CHG_RD : ST_FINISH;
            end
         end
         ST_CHG_RD: begin
            state_in = ST_CHG_EMIT;
         end
         ST_CHG_EMIT: begin
            if (emit_ok) begin
               emit                 = 1'b1;
               emit_data.reply_to   = chg_rd;
               emit_data.reply_kind = ACT_WAIT_CHANGE;
               if (CCW'(ci_ff) + 1'b1 == ccnt_ff) begin
                  ccnt_in  = '0;
                  state_in = ST_FINISH;
               end else begin
                  ci_in    = ci_ff + 1'b1;
                  state_in = ST_CHG_RD;
               end
            end
         end
         ST_FINISH: begin
            if (emit_ok) begin
               flush    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // owner valid bits stand in for clearing the owner ram
   always_comb begin
      owner_vld_in = owner_vld_ff;
      if (own_we) begin
         owner_vld_in[zaddr] = 1'b1;
      end
      vldq_in = owner_vld_ff[zaddr];
   end

   // one reply held back so the final one can carry last
   always_comb begin
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_vld_in  = out_vld_ff;
      if (out_free) begin
         out_vld_in = 1'b0;
      end
      if (emit) begin
         hold_in     = emit_data;
         hold_vld_in = 1'b1;
         if (hold_vld_ff) begin
            out_in      = hold_ff;
            out_last_in = 1'b0;
            out_vld_in  = 1'b1;
         end
      end else if (flush && hold_vld_ff) begin
         out_in      = hold_ff;
         out_last_in = 1'b1;
         out_vld_in  = 1'b1;
         hold_vld_in = 1'b0;
      end
   end

   always_comb begin
      ziu_in = ziu_ff;
      if (csr.valid) begin
         ziu_in = csr.zones_in_use;
      end
   end

   assign csr.ready      = 1'b1;
   assign rsp.valid      = out_vld_ff;
   assign rsp.reply_to   = out_ff.reply_to;
   assign rsp.reply_kind = out_ff.reply_kind;
   assign rsp.granted    = out_ff.granted;
   assign rsp.overflow   = out_ff.overflow;
   assign rsp.last       = out_last_ff;

endmodule

// ===== rtl/zrl_checker.sv =====
`timescale 1ns / 1ps
// zrl_checker: port level checks of the lock table, bound to the top level
// depends on zrl_pkg and zone_reservation_lock_table

module zrl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic       rsp_granted,
   input logic       rsp_overflow
);
   import zrl_pkg::*;

   // one request in flight at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("reply dropped while stalled");

   a_ovf_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_kind == ACT_WAIT || rsp_kind == ACT_WAIT_CHANGE)
      else $error("overflow on a non-wait reply");

   a_grant_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == ACT_WAIT || rsp_kind == ACT_WAIT_CHANGE ||
                    rsp_kind == ACT_UNRESERVE_ALL) |-> !rsp_granted)
      else $error("granted set on a reply without a grant");

endmodule

bind zone_reservation_lock_table zrl_checker u_zrl_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_kind(rsp.reply_kind), .rsp_granted(rsp.granted), .rsp_overflow(rsp.overflow)
);
